@@ src/stst_pkg.sv @@
// shared constants for the segment tree range sum core
package stst_pkg;

    localparam int DEF_MAX_LEAVES = 1024;

    localparam int CFG_W = 11;
    localparam int POS_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 43;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

@@ src/segment_tree_range_sum_core.sv @@
// top level of the segment tree range sum core
// set: leaf write, then one ancestor a cycle up to the root
// query: bottom-up range walk, left edge then right edge at each tree level
// one request at a time; the memory port and the single adder set the pace
// reset: clearing pass writes zero to all 2*MAX_LEAVES nodes, one a cycle,
// before the first request is taken; size register returns to 1024
module segment_tree_range_sum_core #(
    parameter int MAX_LEAVES = stst_pkg::DEF_MAX_LEAVES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write
    input  logic                       i_cfg_we,
    input  logic [stst_pkg::CFG_W-1:0] i_cfg_data,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [stst_pkg::POS_W-1:0] i_position,
    input  logic [stst_pkg::VAL_W-1:0] i_new_value,
    input  logic [stst_pkg::POS_W-1:0] i_range_low,
    input  logic [stst_pkg::POS_W-1:0] i_range_high,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [stst_pkg::SUM_W-1:0] o_range_sum
);
    import stst_pkg::*;

    // node index width: the heap holds nodes 1 .. 2*MAX_LEAVES-1
    localparam int NW    = $clog2(2 * MAX_LEAVES);
    localparam int LIM_W = $clog2(MAX_LEAVES + 1);
    // size compare width, wide enough for both the register and the leaf count
    localparam int SW    = (CFG_W > LIM_W) ? CFG_W : LIM_W;

    logic [CFG_W-1:0] r_size;
    logic [SW-1:0]    size_ext;
    logic [SW-1:0]    eff_size;

    logic             mem_we;
    logic [NW-1:0]    mem_waddr;
    logic [SUM_W-1:0] mem_wdata;
    logic [NW-1:0]    mem_raddr;
    logic [SUM_W-1:0] mem_rdata;

    // size register, written any time the write enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    // saturate the size to 1 .. MAX_LEAVES
    assign size_ext = SW'(r_size);
    always_comb begin
        if (r_size == '0) begin
            eff_size = SW'(1);
        end else if (size_ext > SW'(MAX_LEAVES)) begin
            eff_size = SW'(MAX_LEAVES);
        end else begin
            eff_size = size_ext;
        end
    end

    // sequencer: clearing pass, leaf-to-root update, bottom-up range walk
    stst_ctrl #(
        .MAX_LEAVES (MAX_LEAVES),
        .NW         (NW),
        .SW         (SW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff_size   (eff_size),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_range_sum  (o_range_sum),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // heap of node sums, leaf i at node MAX_LEAVES + i
    stst_mem #(
        .DEPTH  (2 * MAX_LEAVES),
        .ADDR_W (NW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ src/stst_mem.sv @@
// node sum memory, one write port and one registered read port
module stst_mem #(
    parameter int DEPTH  = 2 * stst_pkg::DEF_MAX_LEAVES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [stst_pkg::SUM_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [stst_pkg::SUM_W-1:0] o_rdata
);
    import stst_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/stst_ctrl.sv @@
// sequencer with the shared sum adder, clearing pass and result register
module stst_ctrl #(
    parameter int MAX_LEAVES = stst_pkg::DEF_MAX_LEAVES,
    parameter int NW         = $clog2(2 * MAX_LEAVES),
    parameter int SW         = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [SW-1:0]              i_eff_size,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [stst_pkg::POS_W-1:0] i_position,
    input  logic [stst_pkg::VAL_W-1:0] i_new_value,
    input  logic [stst_pkg::POS_W-1:0] i_range_low,
    input  logic [stst_pkg::POS_W-1:0] i_range_high,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [stst_pkg::SUM_W-1:0] o_range_sum,
    output logic                       o_mem_we,
    output logic [NW-1:0]              o_mem_waddr,
    output logic [stst_pkg::SUM_W-1:0] o_mem_wdata,
    output logic [NW-1:0]              o_mem_raddr,
    input  logic [stst_pkg::SUM_W-1:0] i_mem_rdata
);
    import stst_pkg::*;

    localparam int BW = NW + 1;
    localparam logic [NW-1:0] CLR_LAST = NW'(2 * MAX_LEAVES - 1);
    localparam logic [NW-1:0] ROOT     = NW'(1);

    typedef enum logic [5:0] {
        S_CLR    = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SET_UP = 6'b000100,
        S_Q_A    = 6'b001000,
        S_Q_B    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [NW-1:0]    r_clr, n_clr;
    logic [NW-1:0]    r_k, n_k;
    logic [BW-1:0]    r_a, n_a;
    logic [BW-1:0]    r_b, n_b;
    logic [SUM_W-1:0] r_acc, n_acc;
    logic             r_pend, n_pend;
    logic             r_ov, n_ov;
    logic [SUM_W-1:0] r_out, n_out;

    logic             accept;
    logic [SUM_W-1:0] val_ext;
    logic [NW-1:0]    leaf;
    logic [NW-1:0]    parent;
    logic [SW-1:0]    hi_lim;
    logic [SW-1:0]    hi_ext;
    logic [SW-1:0]    hi_clip;
    logic             empty;
    logic [BW-1:0]    b_dec;
    logic [SUM_W-1:0] add_b;
    logic [SUM_W-1:0] sum;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign val_ext = {{(SUM_W-VAL_W){i_new_value[VAL_W-1]}}, i_new_value};
    assign leaf    = NW'(MAX_LEAVES) + NW'(i_position);
    assign parent  = r_k >> 1;

    assign hi_lim  = i_eff_size - SW'(1);
    assign hi_ext  = SW'(i_range_high);
    assign hi_clip = (hi_ext > hi_lim) ? hi_lim : hi_ext;
    assign empty   = SW'(i_range_low) > hi_clip;
    assign b_dec   = r_b[0] ? (r_b - BW'(1)) : r_b;

    // the one adder, shared by tree updates and range accumulation
    assign add_b = (r_state == S_SET_UP || r_pend) ? i_mem_rdata : '0;
    assign sum   = r_acc + add_b;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_k     = r_k;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_ov    = r_ov;
        n_out   = r_out;

        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + NW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_SET) begin
                        if (SW'(i_position) < i_eff_size) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = leaf;
                            o_mem_wdata = val_ext;
                            o_mem_raddr = leaf ^ NW'(1);
                            n_k         = leaf;
                            n_acc       = val_ext;
                            n_state     = S_SET_UP;
                        end
                    end else begin
                        n_acc  = '0;
                        n_pend = 1'b0;
                        n_a    = BW'(i_range_low) + BW'(MAX_LEAVES);
                        n_b    = BW'(hi_clip) + BW'(MAX_LEAVES) + BW'(1);
                        n_state = empty ? S_DONE : S_Q_A;
                    end
                end
            end
            S_SET_UP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = parent;
                o_mem_wdata = sum;
                o_mem_raddr = parent ^ NW'(1);
                n_acc       = sum;
                n_k         = parent;
                if (parent == ROOT) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_A: begin
                n_acc = sum;
                if (r_a < r_b) begin
                    if (r_a[0]) begin
                        o_mem_raddr = r_a[NW-1:0];
                        n_pend      = 1'b1;
                        n_a         = r_a + BW'(1);
                    end else begin
                        n_pend = 1'b0;
                    end
                    n_state = S_Q_B;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_Q_B: begin
                n_acc = sum;
                if (r_b[0]) begin
                    o_mem_raddr = b_dec[NW-1:0];
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                n_a     = r_a >> 1;
                n_b     = b_dec >> 1;
                n_state = S_Q_A;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_out   = r_acc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_range_sum = r_out;

endmodule
